// File: hdl/dltq_pkg.sv
// Shared types and constants for the delta-list timer queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package dltq_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int IDX_W      = $clog2(MAX_TASKS);
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int SUM_W      = 32 + $clog2(MAX_TASKS) + 1;
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_TICK     = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_DELETE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_op         op;
        logic        tid_zero;
        logic [31:0] task_id;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [15:0] task_handle;
    } t_cmd;

endpackage

`default_nettype wire

// File: hdl/delta_list_task_timer_queue_unit.sv
// Delta-list timer queue: up to MAX_TASKS tasks ordered by due time.
// Tick, add to a full queue and dispatch with nothing due set the result at the accepting edge;
// add scans the running sum (one entry of the running-sum scan per cycle), then inserts; delete
// scans for the id, then folds and removes it; dispatch with re-arm removes, scans and inserts.
// One item at a time through the sequencer, the next only once the result is popped;
// the front queue holds up to two items meanwhile. Synchronous active-low reset empties all.
`default_nettype none

module delta_list_task_timer_queue_unit
    import dltq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command side
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_task_id,
    input  wire logic [31:0] i_start_delay,
    input  wire logic [31:0] i_repeat_period,
    input  wire logic [15:0] i_task_handle,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic             o_fired,
    output logic [31:0]      o_result_id,
    output logic [15:0]      o_fired_handle
);

    // commands travel from the front queue to the engine
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    // front: accept and classify each item, hold up to two
    dltq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_operation     (i_operation),
        .i_task_id       (i_task_id),
        .i_start_delay   (i_start_delay),
        .i_repeat_period (i_repeat_period),
        .i_task_handle   (i_task_handle),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_take      (cmd_take)
    );

    // back: walk the list, insert and remove, hold the result
    dltq_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_take     (cmd_take),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_fired        (o_fired),
        .o_result_id    (o_result_id),
        .o_fired_handle (o_fired_handle)
    );

endmodule

`default_nettype wire

// File: hdl/dltq_front.sv
// Front end: accepts scheduler commands, classifies them and queues them.
// Depends on dltq_pkg.
`default_nettype none

module dltq_front
    import dltq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_task_id,
    input  wire logic [31:0] i_start_delay,
    input  wire logic [31:0] i_repeat_period,
    input  wire logic [15:0] i_task_handle,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_take
);

    t_cmd              r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FCNT_W-1:0] r_cnt, n_cnt;
    logic              wr_en, rd_en;
    t_cmd              in_cmd;

    assign full        = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign wr_en       = push && !full;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    // classify: decode the op and flag a request for a fresh id
    always_comb begin
        in_cmd.op            = t_op'(i_operation);
        in_cmd.tid_zero      = (i_task_id == 32'd0);
        in_cmd.task_id       = i_task_id;
        in_cmd.start_delay   = i_start_delay;
        in_cmd.repeat_period = i_repeat_period;
        in_cmd.task_handle   = i_task_handle;
    end

    always_comb begin
        n_wr_ptr = wr_en ? FPTR_W'((32'(r_wr_ptr) + 1) % FIFO_DEPTH) : r_wr_ptr;
        n_rd_ptr = rd_en ? FPTR_W'((32'(r_rd_ptr) + 1) % FIFO_DEPTH) : r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + FCNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - FCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dltq_engine.sv
// Back end: delta-list storage, the sequencer that searches, inserts and
// removes entries, and the one-entry result register. Depends on dltq_pkg.
`default_nettype none

module dltq_engine
    import dltq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_take,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic             o_fired,
    output logic [31:0]      o_result_id,
    output logic [15:0]      o_fired_handle
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN_ADD = 6'b000010,
        S_INSERT   = 6'b000100,
        S_SCAN_DEL = 6'b001000,
        S_DSUM     = 6'b010000,
        S_REMOVE   = 6'b100000
    } t_state;

    logic [31:0] r_delta  [MAX_TASKS];
    logic [31:0] r_period [MAX_TASKS];
    logic [31:0] r_ident  [MAX_TASKS];
    logic [15:0] r_tag    [MAX_TASKS];

    t_state      r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [31:0] r_last_id, n_last_id;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [31:0] r_split, n_split;
    logic [31:0] r_dsum, n_dsum;
    logic [31:0] r_id, n_id;
    logic [15:0] r_tag_new, n_tag_new;
    logic [31:0] r_delay, n_delay;
    logic [31:0] r_per, n_per;
    logic        r_disp, n_disp;

    logic        r_res_valid, n_res_valid;
    t_status     r_res_status, n_res_status;
    logic        r_res_fired, n_res_fired;
    logic [31:0] r_res_id, n_res_id;
    logic [15:0] r_res_handle, n_res_handle;

    logic [CNT_W-1:0] pos_inc;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0] rd_delta, rd_ident;
    logic [SUM_W-1:0] scan_sum;
    logic        at_end, take, do_tick;
    logic [31:0] own_delta, issued;

    assign pos_inc  = r_pos + CNT_W'(1);
    assign rd_idx   = (r_state == S_DSUM) ? pos_inc[IDX_W-1:0] : r_pos[IDX_W-1:0];
    assign rd_delta = r_delta[rd_idx];
    assign rd_ident = r_ident[rd_idx];
    assign scan_sum = r_sum + SUM_W'(rd_delta);
    assign at_end   = (r_pos == r_count);
    assign own_delta = 32'(SUM_W'(r_delay) - r_sum);
    assign issued   = (r_last_id == 32'hFFFF_FFFF) ? 32'd1 : r_last_id + 32'd1;

    assign take       = (r_state == S_IDLE) && i_cmd_valid && !r_res_valid;
    assign o_cmd_take = take;

    assign empty          = !r_res_valid;
    assign o_status       = r_res_status;
    assign o_fired        = r_res_fired;
    assign o_result_id    = r_res_id;
    assign o_fired_handle = r_res_handle;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_last_id    = r_last_id;
        n_sum        = r_sum;
        n_split      = r_split;
        n_dsum       = r_dsum;
        n_id         = r_id;
        n_tag_new    = r_tag_new;
        n_delay      = r_delay;
        n_per        = r_per;
        n_disp       = r_disp;
        n_res_valid  = r_res_valid && !pop;
        n_res_status = r_res_status;
        n_res_fired  = r_res_fired;
        n_res_id     = r_res_id;
        n_res_handle = r_res_handle;
        do_tick      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    // default result: all zero
                    n_res_valid  = 1'b1;
                    n_res_status = ST_OK;
                    n_res_fired  = 1'b0;
                    n_res_id     = 32'd0;
                    n_res_handle = 16'd0;
                    n_pos        = '0;
                    n_sum        = '0;
                    n_disp       = 1'b0;
                    case (i_cmd.op)
                        OP_ADD: begin
                            if (r_count == CNT_W'(MAX_TASKS)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_res_valid = 1'b0;
                                if (i_cmd.tid_zero) begin
                                    n_last_id = issued;
                                    n_id      = issued;
                                end else begin
                                    n_id = i_cmd.task_id;
                                end
                                n_tag_new = i_cmd.task_handle;
                                n_delay   = i_cmd.start_delay;
                                n_per     = i_cmd.repeat_period;
                                n_state   = S_SCAN_ADD;
                            end
                        end
                        OP_TICK: begin
                            do_tick = (r_count != '0) && (r_delta[0] != 32'd0);
                        end
                        OP_DISPATCH: begin
                            if ((r_count != '0) && (r_delta[0] == 32'd0)) begin
                                n_res_valid = 1'b0;
                                n_disp      = 1'b1;
                                n_id        = r_ident[0];
                                n_tag_new   = r_tag[0];
                                n_delay     = r_period[0];
                                n_per       = r_period[0];
                                n_dsum      = r_delta[0];
                                n_state     = S_DSUM;
                            end
                        end
                        OP_DELETE: begin
                            n_res_valid = 1'b0;
                            n_id        = i_cmd.task_id;
                            n_state     = S_SCAN_DEL;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_ADD: begin
                // walk the running sum until the new delay falls short of it
                if (at_end) begin
                    n_state = S_INSERT;
                end else if (SUM_W'(r_delay) < scan_sum) begin
                    n_split = 32'(scan_sum - SUM_W'(r_delay));
                    n_state = S_INSERT;
                end else begin
                    n_sum = scan_sum;
                    n_pos = pos_inc;
                end
            end
            S_INSERT: begin
                n_count      = r_count + CNT_W'(1);
                n_res_valid  = 1'b1;
                n_res_status = ST_OK;
                n_res_fired  = r_disp;
                n_res_id     = r_id;
                n_res_handle = r_disp ? r_tag_new : 16'd0;
                n_state      = S_IDLE;
            end
            S_SCAN_DEL: begin
                if (at_end) begin
                    n_res_valid  = 1'b1;
                    n_res_status = ST_NOT_FOUND;
                    n_res_id     = r_id;
                    n_state      = S_IDLE;
                end else if (rd_ident == r_id) begin
                    n_dsum  = rd_delta;
                    n_state = S_DSUM;
                end else begin
                    n_pos = pos_inc;
                end
            end
            S_DSUM: begin
                // fold the removed delta into its successor
                if (pos_inc < r_count) begin
                    n_dsum = r_dsum + rd_delta;
                end
                n_state = S_REMOVE;
            end
            S_REMOVE: begin
                n_count = r_count - CNT_W'(1);
                if (r_disp && (r_per != 32'd0)) begin
                    n_pos   = '0;
                    n_sum   = '0;
                    n_state = S_SCAN_ADD;
                end else begin
                    n_res_valid  = 1'b1;
                    n_res_status = ST_OK;
                    n_res_fired  = r_disp;
                    n_res_id     = r_id;
                    n_res_handle = r_disp ? r_tag_new : 16'd0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last_id   <= 32'd0;
            r_res_valid <= 1'b0;
            r_disp      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last_id   <= n_last_id;
            r_res_valid <= n_res_valid;
            r_disp      <= n_disp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_sum        <= n_sum;
        r_split      <= n_split;
        r_dsum       <= n_dsum;
        r_id         <= n_id;
        r_tag_new    <= n_tag_new;
        r_delay      <= n_delay;
        r_per        <= n_per;
        r_res_status <= n_res_status;
        r_res_fired  <= n_res_fired;
        r_res_id     <= n_res_id;
        r_res_handle <= n_res_handle;
    end

    // entry row: every cell reads only itself and its two neighbors
    always_ff @(posedge i_clk) begin
        if (do_tick) begin
            r_delta[0] <= r_delta[0] - 32'd1;
        end
        if (r_state == S_INSERT) begin
            for (int k = 0; k < MAX_TASKS; k++) begin
                if (CNT_W'(k) == r_pos) begin
                    r_delta[k]  <= own_delta;
                    r_period[k] <= r_per;
                    r_ident[k]  <= r_id;
                    r_tag[k]    <= r_tag_new;
                end else if ((k > 0) && (CNT_W'(k) > r_pos)) begin
                    r_delta[k]  <= (CNT_W'(k) == pos_inc) ? r_split
                                                          : r_delta[(k + MAX_TASKS - 1) % MAX_TASKS];
                    r_period[k] <= r_period[(k + MAX_TASKS - 1) % MAX_TASKS];
                    r_ident[k]  <= r_ident[(k + MAX_TASKS - 1) % MAX_TASKS];
                    r_tag[k]    <= r_tag[(k + MAX_TASKS - 1) % MAX_TASKS];
                end
            end
        end
        if (r_state == S_REMOVE) begin
            for (int k = 0; k < MAX_TASKS - 1; k++) begin
                if (CNT_W'(k) >= r_pos) begin
                    r_delta[k]  <= (CNT_W'(k) == r_pos) ? r_dsum : r_delta[k + 1];
                    r_period[k] <= r_period[k + 1];
                    r_ident[k]  <= r_ident[k + 1];
                    r_tag[k]    <= r_tag[k + 1];
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TASKS))
        else $error("queue count above capacity");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !pop |=> r_res_valid && $stable(r_res_id))
        else $error("pending result lost or changed");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INSERT |-> r_count < CNT_W'(MAX_TASKS))
        else $error("insert into a full queue");

    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res_fired |-> r_res_status == ST_OK)
        else $error("fired result with error status");

endmodule

`default_nettype wire

// File: tb/tb_delta_list_task_timer_queue_unit.sv
// Self-checking bench for the delta-list timer queue: directed and random items.
// Depends on dltq_pkg and delta_list_task_timer_queue_unit.
`default_nettype none

module tb_delta_list_task_timer_queue_unit;
    import dltq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_status     status;
        logic        fired;
        logic [31:0] rid;
        logic [15:0] handle;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_operation;
    logic [31:0] i_task_id;
    logic [31:0] i_start_delay;
    logic [31:0] i_repeat_period;
    logic [15:0] i_task_handle;
    logic        empty;
    logic        pop;
    logic [1:0]  o_status;
    logic        o_fired;
    logic [31:0] o_result_id;
    logic [15:0] o_fired_handle;

    delta_list_task_timer_queue_unit DUT (.*);

    // Shadow copy of the timer list.
    logic [31:0] q_delta  [MAX_TASKS+1];
    logic [31:0] q_period [MAX_TASKS+1];
    logic [31:0] q_ident  [MAX_TASKS+1];
    logic [15:0] q_tag    [MAX_TASKS+1];
    int          q_count;
    logic [31:0] last_id;

    t_outcome    pending_outcomes[$];
    int          errors;
    int          cycles;
    logic        pop_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Insert keeping due-time order; ties go after existing entries.
    function automatic void list_insert(input logic [31:0] dly, input logic [31:0] per,
                                        input logic [31:0] id, input logic [15:0] tag);
        logic [33+IDX_W:0] sum;
        logic [33+IDX_W:0] prior;
        int pos;
        sum = '0;
        pos = 0;
        while (pos < q_count) begin
            sum += q_delta[pos];
            if (dly < sum) break;
            pos++;
        end
        if (pos == q_count) begin
            q_delta[pos] = dly - sum[31:0];
        end else begin
            prior = sum - q_delta[pos];
            q_delta[pos] = 32'(sum - dly);
            for (int k = q_count; k > pos; k--) begin
                q_delta[k]  = q_delta[k-1];
                q_period[k] = q_period[k-1];
                q_ident[k]  = q_ident[k-1];
                q_tag[k]    = q_tag[k-1];
            end
            q_delta[pos] = dly - prior[31:0];
        end
        q_period[pos] = per;
        q_ident[pos]  = id;
        q_tag[pos]    = tag;
        q_count++;
    endfunction

    // Remove an entry and fold its delta into the successor.
    function automatic void list_remove(input int pos);
        if (pos + 1 < q_count) q_delta[pos+1] = q_delta[pos+1] + q_delta[pos];
        for (int k = pos; k + 1 < q_count; k++) begin
            q_delta[k]  = q_delta[k+1];
            q_period[k] = q_period[k+1];
            q_ident[k]  = q_ident[k+1];
            q_tag[k]    = q_tag[k+1];
        end
        q_count--;
    endfunction

    // Advance the shadow list by one item and return the outcome it causes.
    function automatic t_outcome timer_step(input t_op op, input logic [31:0] tid,
                                            input logic [31:0] dly, input logic [31:0] per,
                                            input logic [15:0] tag);
        t_outcome r;
        logic [31:0] id;
        logic [31:0] p;
        int pos;
        r = '{ST_OK, 1'b0, 32'd0, 16'd0};
        case (op)
            OP_ADD: begin
                if (q_count >= MAX_TASKS) begin
                    r.status = ST_FULL;
                end else begin
                    if (tid == 0) begin
                        last_id = last_id + 1;
                        if (last_id == 0) last_id = 1;
                        id = last_id;
                    end else begin
                        id = tid;
                    end
                    list_insert(dly, per, id, tag);
                    r.rid = id;
                end
            end
            OP_TICK: begin
                if (q_count > 0 && q_delta[0] > 0) q_delta[0]--;
            end
            OP_DISPATCH: begin
                if (q_count > 0 && q_delta[0] == 0) begin
                    p = q_period[0];
                    r.fired = 1'b1;
                    r.rid = q_ident[0];
                    r.handle = q_tag[0];
                    id = q_ident[0];
                    list_remove(0);
                    if (p != 0) list_insert(p, p, id, r.handle);
                end
            end
            default: begin
                pos = 0;
                while (pos < q_count && q_ident[pos] != tid) pos++;
                r.rid = tid;
                if (pos < q_count) list_remove(pos);
                else r.status = ST_NOT_FOUND;
            end
        endcase
        return r;
    endfunction

    // Send one item, with a random gap ahead of it on burst boundaries.
    int burst_left;
    task automatic send_item(input t_op op, input logic [31:0] tid, input logic [31:0] dly,
                             input logic [31:0] per, input logic [15:0] tag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push            <= 1'b1;
        i_operation     <= op;
        i_task_id       <= tid;
        i_start_delay   <= dly;
        i_repeat_period <= per;
        i_task_handle   <= tag;
        do @(posedge i_clk); while (full);
        pending_outcomes.push_back(timer_step(op, tid, dly, per, tag));
    endtask

    // Hold the sender idle until every expected result is back.
    task automatic drain_outcomes();
        push <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stall pattern: alternating runs of steady pop and random stalls.
    initial begin
        pop_hold = 1'b0;
        forever begin
            repeat ($urandom_range(20, 80)) begin
                @(posedge i_clk);
                pop <= pop_hold ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
            pop_hold = ~pop_hold;
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome x;
        if (i_rst_n && pop && !empty) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result status=%0d id=%h", $time, o_status,
                         o_result_id);
                errors++;
            end else begin
                x = pending_outcomes.pop_front();
                if (o_status !== x.status || o_fired !== x.fired ||
                    o_result_id !== x.rid || o_fired_handle !== x.handle) begin
                    $display("%0t: mismatch expected st=%0d f=%0d id=%h h=%h actual st=%0d f=%0d id=%h h=%h",
                             $time, x.status, x.fired, x.rid, x.handle,
                             o_status, o_fired, o_result_id, o_fired_handle);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 4);
            3: return $urandom_range(0, 20);
            default: return $urandom();
        endcase
    endfunction

    // Directed: field extremes, every operation and tie cases.
    task automatic test_directed();
        send_item(OP_DISPATCH, 0, 0, 0, 0);            // empty queue
        send_item(OP_TICK, 0, 0, 0, 0);                // tick on empty
        send_item(OP_DELETE, 32'hFFFF_FFFF, 0, 0, 0);  // unknown id
        send_item(OP_ADD, 0, 3, 2, 16'hFFFF);
        send_item(OP_ADD, 0, 3, 0, 16'h0001);          // tie goes after
        send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
        send_item(OP_ADD, 7, 0, 1, 16'h1234);
        send_item(OP_DISPATCH, 0, 0, 0, 0);
        repeat (3) send_item(OP_TICK, 0, 0, 0, 0);
        repeat (3) send_item(OP_DISPATCH, 0, 0, 0, 0);
        send_item(OP_DELETE, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(OP_DELETE, 7, 0, 0, 0);
        drain_outcomes();
    endtask

    // Fill past capacity, then flush with deletes; the issued-id counter runs on.
    task automatic test_full_queue();
        logic [31:0] ids[$];
        for (int k = 0; k < MAX_TASKS + 2; k++)
            send_item(OP_ADD, 0, $urandom_range(0, 5), $urandom_range(0, 3),
                      $urandom());
        drain_outcomes();
        for (int k = 0; k < q_count; k++) ids.push_back(q_ident[k]);
        foreach (ids[k]) send_item(OP_DELETE, ids[k], 0, 0, 0);
    endtask

    // Mostly well-formed scheduling traffic with random content.
    task automatic test_random(input int n);
        t_op op;
        logic [31:0] tid;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: op = OP_ADD;
                3, 4, 5: op = OP_TICK;
                6, 7:    op = OP_DISPATCH;
                default: op = OP_DELETE;
            endcase
            tid = ($urandom_range(0, 2) == 0) ? rand_word() : 32'd0;
            if (op == OP_DELETE && q_count > 0 && $urandom_range(0, 3) != 0)
                tid = q_ident[$urandom_range(0, q_count - 1)];
            send_item(op, tid, rand_word(), rand_word(), $urandom());
            if (k == n / 2) drain_outcomes();   // hold off until all results are back
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        burst_left = 0;
        q_count = 0;
        last_id = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_operation = OP_ADD;
        i_task_id = 0;
        i_start_delay = 0;
        i_repeat_period = 0;
        i_task_handle = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_queue();
        test_random(1700);
        drain_outcomes();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
